>>> rtl/core/cartesian_to_spherical_unit_defines.svh
// Assertion macros used by the checker file of the spherical conversion unit.
// Depends on nothing; included by the checker module.
`ifndef CARTESIAN_TO_SPHERICAL_UNIT_DEFINES_SVH
`define CARTESIAN_TO_SPHERICAL_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define C2S_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("spherical unit check failed");

// Antecedent in a cycle implies the consequent in the same cycle.
`define C2S_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spherical unit check failed");

`endif

>>> rtl/core/c2s_pkg.sv
// Shared constants, types and tables of the cartesian to spherical unit.
// Depends on nothing; imported by every module of the unit.
package c2s_pkg;

  // Coordinate and fixed-point formats.
  localparam int COORD_W      = 16;
  localparam int SCALE_BITS   = 32 - COORD_W;
  localparam int SQ_W         = 2 * COORD_W - 1;
  localparam int SUM_W        = 2 * COORD_W;
  localparam int RADIUS_W     = 24;
  localparam int RADIUS_FRAC  = 8;
  localparam int RADIUS_SHIFT = 2 * RADIUS_FRAC + 2;
  localparam int AZ_W         = 16;
  localparam int POL_W        = 15;

  // Square root pipeline: one root bit per stage.
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQRT_STEPS = ROOT_W;

  // CORDIC datapath.
  localparam int ANGLE_STAGES = 16;
  localparam int ATAN_LEN     = 24;
  localparam int VEC_W        = 36;
  localparam int ACC_W        = 36;
  localparam int ACC_FRAC     = 30;
  localparam int ANG_FRAC     = 13;
  localparam int ROUND_SHIFT  = ACC_FRAC - ANG_FRAC;

  localparam logic signed [ACC_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [ACC_W-1:0] ROUND_BIAS  = ACC_W'(1) <<< (ROUND_SHIFT - 1);
  localparam int                      PI_Q13      = 25736;
  localparam logic [RADIUS_W-1:0]     RADIUS_MAX  = {RADIUS_W{1'b1}};

  // Cycles from an accepted request to its result strobe.
  localparam int LATENCY = 3 + SQRT_STEPS + (ANGLE_STAGES + 1) + 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  // Per-point data that rides along the square root pipeline.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   origin;
  } side_t;

  // Partial result of the digit-by-digit square root.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_acc_t;

  // One CORDIC stage: vector, angle accumulator, and a flag for axis cases.
  typedef struct packed {
    logic signed [VEC_W-1:0] cx;
    logic signed [VEC_W-1:0] cy;
    logic signed [ACC_W-1:0] acc;
    logic                    hold;
  } cordic_t;

  // atan(2^-i) in units of 2^-30 rad, rounded.
  function automatic logic signed [ACC_W-1:0] atan_q30(input int idx);
    logic signed [ACC_W-1:0] v;
    case (idx)
      0:       v = 36'sd843314857;
      1:       v = 36'sd497837829;
      2:       v = 36'sd263043837;
      3:       v = 36'sd133525159;
      4:       v = 36'sd67021687;
      5:       v = 36'sd33543516;
      6:       v = 36'sd16775851;
      7:       v = 36'sd8388437;
      8:       v = 36'sd4194283;
      9:       v = 36'sd2097149;
      10:      v = 36'sd1048576;
      11:      v = 36'sd524288;
      12:      v = 36'sd262144;
      13:      v = 36'sd131072;
      14:      v = 36'sd65536;
      15:      v = 36'sd32768;
      16:      v = 36'sd16384;
      17:      v = 36'sd8192;
      18:      v = 36'sd4096;
      19:      v = 36'sd2048;
      20:      v = 36'sd1024;
      21:      v = 36'sd512;
      22:      v = 36'sd256;
      23:      v = 36'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/c2s_square.sv
// Front end of the spherical unit: input capture, squares and sums of squares.
// Depends on c2s_pkg.
module c2s_square
  import c2s_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  input  coord_t           x_i,
  input  coord_t           y_i,
  input  coord_t           z_i,
  output logic             valid_o,
  output logic [SUM_W-1:0] xy2_o,
  output logic [SUM_W-1:0] sum_o,
  output side_t            side_o
);

  logic             v0_r, v1_r, v2_r;
  coord_t           x0_r, y0_r, z0_r;
  logic [SQ_W-1:0]  xx_r, yy_r, zz_r;
  side_t            side1_r, side2_r;
  logic [SUM_W-1:0] xy2_r, sum_r;

  logic signed [2*COORD_W-1:0] xx_full, yy_full, zz_full;
  logic [SUM_W-1:0]            xy2_nxt;

  // Full-precision signed squares.
  assign xx_full = (2*COORD_W)'(x0_r) * (2*COORD_W)'(x0_r);
  assign yy_full = (2*COORD_W)'(y0_r) * (2*COORD_W)'(y0_r);
  assign zz_full = (2*COORD_W)'(z0_r) * (2*COORD_W)'(z0_r);
  assign xy2_nxt = SUM_W'(xx_r) + SUM_W'(yy_r);

  // Valid bits of the three stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= valid_i;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // Datapath: capture, multiply, add.
  always_ff @(posedge clk) begin
    x0_r           <= x_i;
    y0_r           <= y_i;
    z0_r           <= z_i;
    xx_r           <= xx_full[SQ_W-1:0];
    yy_r           <= yy_full[SQ_W-1:0];
    zz_r           <= zz_full[SQ_W-1:0];
    side1_r.x      <= x0_r;
    side1_r.y      <= y0_r;
    side1_r.z      <= z0_r;
    side1_r.origin <= (x0_r == '0) && (y0_r == '0) && (z0_r == '0);
    xy2_r          <= xy2_nxt;
    sum_r          <= xy2_nxt + SUM_W'(zz_r);
    side2_r        <= side1_r;
  end

  assign valid_o = v2_r;
  assign xy2_o   = xy2_r;
  assign sum_o   = sum_r;
  assign side_o  = side2_r;

endmodule

>>> rtl/core/c2s_sqrt.sv
// Two parallel pipelined integer square roots, one root bit per stage.
// Depends on c2s_pkg.
module c2s_sqrt
  import c2s_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_a_i,
  input  logic [RAD_W-1:0]  rad_b_i,
  input  side_t             side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_a_o,
  output logic [ROOT_W-1:0] root_b_o,
  output side_t             side_o
);

  logic [SQRT_STEPS-1:0] v_r;
  sq_acc_t               acc_a_r   [SQRT_STEPS];
  sq_acc_t               acc_b_r   [SQRT_STEPS];
  sq_acc_t               acc_a_nxt [SQRT_STEPS];
  sq_acc_t               acc_b_nxt [SQRT_STEPS];
  sq_acc_t               acc_a_in  [SQRT_STEPS];
  sq_acc_t               acc_b_in  [SQRT_STEPS];
  logic [RAD_W-1:0]      rad_a_r   [SQRT_STEPS];
  logic [RAD_W-1:0]      rad_b_r   [SQRT_STEPS];
  logic [RAD_W-1:0]      rad_a_in  [SQRT_STEPS];
  logic [RAD_W-1:0]      rad_b_in  [SQRT_STEPS];
  side_t                 side_r    [SQRT_STEPS];
  side_t                 side_in   [SQRT_STEPS];

  // One restoring step: bring down two radicand bits and try a root bit of one.
  function automatic sq_acc_t sqrt_step(input sq_acc_t cur, input logic [1:0] pair);
    logic [REM_W+1:0] rem_sh;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    sq_acc_t          res;
    rem_sh = {cur.rem, pair};
    trial  = {2'b00, cur.root, 2'b01};
    diff   = rem_sh - trial;
    if (rem_sh >= trial) begin
      res.rem  = diff[REM_W-1:0];
      res.root = {cur.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = rem_sh[REM_W-1:0];
      res.root = {cur.root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  // Stage inputs: the first stage starts from zero, the others from the stage before.
  always_comb begin
    acc_a_in[0] = '0;
    acc_b_in[0] = '0;
    rad_a_in[0] = rad_a_i;
    rad_b_in[0] = rad_b_i;
    side_in[0]  = side_i;
    for (int j = 1; j < SQRT_STEPS; j++) begin
      acc_a_in[j] = acc_a_r[j-1];
      acc_b_in[j] = acc_b_r[j-1];
      rad_a_in[j] = rad_a_r[j-1];
      rad_b_in[j] = rad_b_r[j-1];
      side_in[j]  = side_r[j-1];
    end
  end

  // Stage j settles root bit SQRT_STEPS-1-j from radicand bits taken high first.
  always_comb begin
    for (int j = 0; j < SQRT_STEPS; j++) begin
      acc_a_nxt[j] = sqrt_step(acc_a_in[j], rad_a_in[j][RAD_W-1-2*j -: 2]);
      acc_b_nxt[j] = sqrt_step(acc_b_in[j], rad_b_in[j][RAD_W-1-2*j -: 2]);
    end
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[SQRT_STEPS-2:0], valid_i};
    end
  end

  // Stage registers.
  always_ff @(posedge clk) begin
    acc_a_r <= acc_a_nxt;
    acc_b_r <= acc_b_nxt;
    rad_a_r <= rad_a_in;
    rad_b_r <= rad_b_in;
    side_r  <= side_in;
  end

  assign valid_o  = v_r[SQRT_STEPS-1];
  assign root_a_o = acc_a_r[SQRT_STEPS-1].root;
  assign root_b_o = acc_b_r[SQRT_STEPS-1].root;
  assign side_o   = side_r[SQRT_STEPS-1];

endmodule

>>> rtl/core/c2s_cordic.sv
// Pipelined CORDIC vectoring pass giving atan2(cy, cx) in Q6.30 radians.
// Depends on c2s_pkg.
module c2s_cordic
  import c2s_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    valid_i,
  input  logic signed [VEC_W-1:0] cx_i,
  input  logic signed [VEC_W-1:0] cy_i,
  output logic                    valid_o,
  output logic signed [ACC_W-1:0] angle_o
);

  logic [ANGLE_STAGES:0] v_r;
  cordic_t               st_r   [ANGLE_STAGES+1];
  cordic_t               st_nxt [ANGLE_STAGES+1];
  cordic_t               prep;

  // Axis directions get an exact angle; the left half plane is folded over.
  always_comb begin
    prep.cx   = cx_i;
    prep.cy   = cy_i;
    prep.acc  = '0;
    prep.hold = 1'b0;
    if (cy_i == '0) begin
      prep.hold = 1'b1;
      prep.acc  = cx_i[VEC_W-1] ? PI_Q30 : '0;
    end else if (cx_i == '0) begin
      prep.hold = 1'b1;
      prep.acc  = cy_i[VEC_W-1] ? -HALF_PI_Q30 : HALF_PI_Q30;
    end else if (cx_i[VEC_W-1]) begin
      prep.acc = cy_i[VEC_W-1] ? -PI_Q30 : PI_Q30;
      prep.cx  = -cx_i;
      prep.cy  = -cy_i;
    end
  end

  // Micro-rotations: drive cy toward zero and accumulate the angle used.
  always_comb begin
    st_nxt[0] = prep;
    for (int i = 0; i < ANGLE_STAGES; i++) begin
      st_nxt[i+1] = st_r[i];
      if (!st_r[i].hold) begin
        if (!st_r[i].cy[VEC_W-1] && (st_r[i].cy != '0)) begin
          st_nxt[i+1].cx  = st_r[i].cx + (st_r[i].cy >>> i);
          st_nxt[i+1].cy  = st_r[i].cy - (st_r[i].cx >>> i);
          st_nxt[i+1].acc = st_r[i].acc + atan_q30(i);
        end else begin
          st_nxt[i+1].cx  = st_r[i].cx - (st_r[i].cy >>> i);
          st_nxt[i+1].cy  = st_r[i].cy + (st_r[i].cx >>> i);
          st_nxt[i+1].acc = st_r[i].acc - atan_q30(i);
        end
      end
    end
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[ANGLE_STAGES-1:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign valid_o = v_r[ANGLE_STAGES];
  assign angle_o = st_r[ANGLE_STAGES].acc;

endmodule

>>> rtl/core/cartesian_to_spherical_unit.sv
// Top level of the cartesian to spherical conversion unit.
// Depends on c2s_pkg, c2s_square, c2s_sqrt and c2s_cordic.
//
// Converts one signed 16-bit point (x, y, z) per clock into radius (Q.8),
// azimuth atan2(y, x) in signed Q3.13 radians and polar angle
// atan2(sqrt(x^2+y^2), z) in unsigned Q2.13 radians. A request is taken at
// every clock edge where start is high and busy is low; busy is high only
// while rst_n is low. Each result is marked by a one-cycle out_valid strobe,
// in request order. On its way it passes input capture, squaring and
// summing, the bit-per-stage square root, the 16-iteration CORDIC passes and
// one output register. The receiver cannot hold results off, so it must take
// each strobed result. At the origin the angles read zero and out_at_origin
// is set.
module cartesian_to_spherical_unit
  import c2s_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  coord_t              in_coord_x,
  input  coord_t              in_coord_y,
  input  coord_t              in_coord_z,
  output logic                out_valid,
  output logic [RADIUS_W-1:0] out_radius,
  output logic signed [AZ_W-1:0] out_azimuth,
  output logic [POL_W-1:0]    out_polar_angle,
  output logic                out_at_origin
);

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic                origin;
  } rad_dly_t;

  logic                    sq_valid;
  logic [SUM_W-1:0]        sq_xy2, sq_sum;
  side_t                   sq_side;
  logic                    rt_valid;
  logic [ROOT_W-1:0]       rt_root_a, rt_root_b;
  side_t                   rt_side;
  logic [ROOT_W:0]         radius_full;
  rad_dly_t                dly_in;
  rad_dly_t                dly_r [ANGLE_STAGES+1];
  logic signed [VEC_W-1:0] az_cx, az_cy, pol_cx, pol_cy;
  logic                    az_valid, pol_valid;
  logic signed [ACC_W-1:0] az_angle, pol_angle;
  logic signed [ACC_W-1:0] az_q13, pol_q13;

  logic                    out_valid_r;
  logic [RADIUS_W-1:0]     out_radius_r;
  logic signed [AZ_W-1:0]  out_azimuth_r;
  logic [POL_W-1:0]        out_polar_r;
  logic                    out_origin_r;

  // Round Q6.30 half-up to Q3.13 and clamp into [lo, hi].
  function automatic logic signed [ACC_W-1:0] to_q13(input logic signed [ACC_W-1:0] a,
                                                     input logic signed [ACC_W-1:0] lo,
                                                     input logic signed [ACC_W-1:0] hi);
    logic signed [ACC_W-1:0] r;
    r = (a + ROUND_BIAS) >>> ROUND_SHIFT;
    if (r < lo) begin
      r = lo;
    end
    if (r > hi) begin
      r = hi;
    end
    return r;
  endfunction

  assign busy = !rst_n;

  // Squares and sums of squares.
  c2s_square u_square (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (start && !busy),
    .x_i     (in_coord_x),
    .y_i     (in_coord_y),
    .z_i     (in_coord_z),
    .valid_o (sq_valid),
    .xy2_o   (sq_xy2),
    .sum_o   (sq_sum),
    .side_o  (sq_side)
  );

  // Radius root (with one extra bit for rounding) and scaled rho root.
  c2s_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (sq_valid),
    .rad_a_i  (RAD_W'(sq_sum) << RADIUS_SHIFT),
    .rad_b_i  (RAD_W'(sq_xy2) << (2 * SCALE_BITS)),
    .side_i   (sq_side),
    .valid_o  (rt_valid),
    .root_a_o (rt_root_a),
    .root_b_o (rt_root_b),
    .side_o   (rt_side)
  );

  // Radius rounded to nearest, saturated to the output width.
  assign radius_full   = ((ROOT_W+1)'(rt_root_a) + (ROOT_W+1)'(1)) >> 1;
  assign dly_in.radius = (radius_full > (ROOT_W+1)'(RADIUS_MAX)) ? RADIUS_MAX
                                                                  : radius_full[RADIUS_W-1:0];
  assign dly_in.origin = rt_side.origin;

  // CORDIC operands scaled to the common vector format.
  assign az_cx  = VEC_W'(rt_side.x) <<< SCALE_BITS;
  assign az_cy  = VEC_W'(rt_side.y) <<< SCALE_BITS;
  assign pol_cx = VEC_W'(rt_side.z) <<< SCALE_BITS;
  assign pol_cy = $signed(VEC_W'(rt_root_b));

  c2s_cordic u_cordic_az (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (rt_valid),
    .cx_i    (az_cx),
    .cy_i    (az_cy),
    .valid_o (az_valid),
    .angle_o (az_angle)
  );

  c2s_cordic u_cordic_pol (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (rt_valid),
    .cx_i    (pol_cx),
    .cy_i    (pol_cy),
    .valid_o (pol_valid),
    .angle_o (pol_angle)
  );

  // Radius and origin flag wait alongside the CORDIC stages.
  always_ff @(posedge clk) begin
    dly_r[0] <= dly_in;
    for (int i = 1; i <= ANGLE_STAGES; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  assign az_q13  = to_q13(az_angle, -ACC_W'(PI_Q13), ACC_W'(PI_Q13));
  assign pol_q13 = to_q13(pol_angle, '0, ACC_W'(PI_Q13));

  // Output register and result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= az_valid && pol_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_radius_r  <= dly_r[ANGLE_STAGES].radius;
    out_origin_r  <= dly_r[ANGLE_STAGES].origin;
    out_azimuth_r <= dly_r[ANGLE_STAGES].origin ? '0 : az_q13[AZ_W-1:0];
    out_polar_r   <= dly_r[ANGLE_STAGES].origin ? '0 : pol_q13[POL_W-1:0];
  end

  assign out_valid       = out_valid_r;
  assign out_radius      = out_radius_r;
  assign out_azimuth     = out_azimuth_r;
  assign out_polar_angle = out_polar_r;
  assign out_at_origin   = out_origin_r;

endmodule

>>> rtl/core/c2s_checker.sv
// Port-level checks of the cartesian to spherical unit, bound to its top level.
// Depends on c2s_pkg and cartesian_to_spherical_unit_defines.svh.
`include "cartesian_to_spherical_unit_defines.svh"

module c2s_checker
  import c2s_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input coord_t                 in_coord_x,
  input coord_t                 in_coord_y,
  input coord_t                 in_coord_z,
  input logic                   out_valid,
  input logic [RADIUS_W-1:0]    out_radius,
  input logic signed [AZ_W-1:0] out_azimuth,
  input logic [POL_W-1:0]       out_polar_angle,
  input logic                   out_at_origin
);

  logic req_fire;
  logic zero_point;
  logic origin_res;
  logic zero_result;
  logic angles_ok;

  // Terms used by the checks below.
  assign req_fire    = start && !busy;
  assign zero_point  = (in_coord_x == '0) && (in_coord_y == '0) && (in_coord_z == '0);
  assign origin_res  = out_valid && out_at_origin;
  assign zero_result = (out_radius == '0) && (out_azimuth == '0) && (out_polar_angle == '0);
  assign angles_ok   = (out_azimuth <= PI_Q13) && (out_azimuth >= -PI_Q13)
                       && (out_polar_angle <= PI_Q13);

  // Every result strobe traces back to an earlier request.
  `C2S_ASSERT_IMPLY(a_result_has_request, clk, rst_n, out_valid, $past(req_fire, LATENCY))

  // An origin result comes from a zero point and carries zero radius and angles.
  `C2S_ASSERT_IMPLY(a_origin_from_zero, clk, rst_n, origin_res, $past(zero_point, LATENCY))
  `C2S_ASSERT_IMPLY(a_origin_zeros, clk, rst_n, origin_res, zero_result)

  // Angles stay within their documented ranges.
  `C2S_ASSERT_ALWAYS(a_angle_range, clk, rst_n, !out_valid || angles_ok)

endmodule

bind cartesian_to_spherical_unit c2s_checker u_c2s_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_coord_x      (in_coord_x),
  .in_coord_y      (in_coord_y),
  .in_coord_z      (in_coord_z),
  .out_valid       (out_valid),
  .out_radius      (out_radius),
  .out_azimuth     (out_azimuth),
  .out_polar_angle (out_polar_angle),
  .out_at_origin   (out_at_origin)
);
